### src/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg: shared types and constants for the timed linear ramp
// Holds operation codes, controller states, the command and status bundles
// between controller and datapath, and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package tlr_pkg;

    // Fraction bits of the elapsed/duration ratio used for interpolation.
    localparam int T_FRAC = 16;
    // Default number of fraction bits of the value format.
    localparam int FRAC_BITS_DEF = 16;
    // Width of a difference or magnitude of two 32-bit signed values.
    localparam int MAG_W = 33;
    // Milliseconds per second, used for the speed-derived duration.
    localparam int TIME_SCALE = 1000;
    // Bits needed to hold TIME_SCALE.
    localparam int TIME_SCALE_W = 10;
    // A change below one ten-thousandth of a unit snaps to the goal.
    localparam int THRESH_DIV = 10000;
    // Iterations of the divider for the interpolation fraction.
    localparam int FRAC_ITER = T_FRAC + 1;
    // Largest ramp duration in milliseconds.
    localparam logic [30:0] MAX_RAMP_MS = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_SET_DUR   = 2'd0,
        OP_SET_SPEED = 2'd1,
        OP_SAMPLE    = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHK,
        S_FDIV,
        S_MUL,
        S_ADD,
        S_POST,
        S_SPD_ABS,
        S_SPD_MUL,
        S_SPD_DIVS,
        S_SDIV,
        S_SMS,
        S_SMS2,
        S_SET,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;      // capture the input transaction
        logic smp_idle;     // sample of an idle ramp: start value
        logic smp_stop;     // zero-length ramp: stop, keep start value
        logic smp_end;      // time past the end: finish the ramp
        logic div_frac;     // start the elapsed/duration division
        logic div_spd;      // start the distance/speed division
        logic mul;          // delta times fraction
        logic add;          // round and add to the start value
        logic sv_from_smp;  // start value takes the sampled value
        logic snap;         // jump to the goal, stop ramping
        logic spd_abs;      // distance magnitude
        logic spd_mul;      // distance times milliseconds per second
        logic ms_from_div;  // saturated duration from the quotient
        logic start_ramp;   // begin a new ramp
        logic out_load;     // fill the result register
        logic out_sel_smp;  // result carries the sampled value
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic dur_zero;
        logic el_gt_dur;
        logic ms_zero;
        logic sv_eq_goal;
        logic smp_eq_goal;
        logic speed_zero;
        logic below_thresh;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

### src/tlr_div.sv
// ----------------------------------------------------------------------------
// tlr_div: iterative restoring divider
// One quotient bit per cycle. The dividend is MSB-aligned and shifted in
// after a preloaded partial remainder; the iteration count is given at start.
// ----------------------------------------------------------------------------
module tlr_div
    import tlr_pkg::*;
#(
    parameter int DIV_W = 27
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_rem_init,
    input  logic [DIV_W-1:0]             i_dividend,
    input  logic [31:0]                  i_divisor,
    input  logic [$clog2(DIV_W+1)-1:0]   i_count,
    output logic [DIV_W-1:0]             o_quotient,
    output logic                         o_done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_dsr, n_dsr;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [32:0]      w_trial;
    logic [32:0]      w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_count;
            n_rem  = i_rem_init;
            n_dsr  = i_divisor;
            n_dvd  = i_dividend;
            n_quo  = '0;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so 32 bits hold it.
            n_rem = w_ge ? w_diff[31:0] : w_trial[31:0];
            n_dvd = {r_dvd[DIV_W-2:0], 1'b0};
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

### src/tlr_datapath.sv
// ----------------------------------------------------------------------------
// tlr_datapath: ramp state, arithmetic and result register
// Holds start/end value and time, the captured transaction, the shared
// divider, the interpolation multiplier and the output register.
// ----------------------------------------------------------------------------
module tlr_datapath
    import tlr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic signed [31:0] i_goal_value,
    input  logic [30:0]        i_ramp_ms,
    input  logic [15:0]        i_units_per_second,
    input  logic [31:0]        i_now_ms,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_current_value,
    output logic signed [31:0] o_goal_out,
    output logic               o_ramping
);

    localparam int NUM_W  = MAG_W + TIME_SCALE_W;
    localparam int DIV_W  = NUM_W - FRAC_BITS;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int PROD_W = MAG_W + T_FRAC + 2;
    localparam int THRESH = ((1 << FRAC_BITS) + THRESH_DIV - 1) / THRESH_DIV;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (T_FRAC - 1);

    // Ramp state
    logic [31:0] r_sv, r_ev, r_st, r_et;
    logic        r_active;
    // Captured transaction and working registers
    logic [31:0]              r_goal, r_now;
    logic [30:0]              r_ms;
    logic [15:0]              r_speed;
    logic [31:0]              r_smp;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]         r_mag;
    logic [DIV_W-1:0]         r_num;
    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_cur, r_out_goal;
    logic        r_out_ramp;

    logic [31:0]              w_dur, w_el;
    logic signed [MAG_W-1:0]  w_delta, w_dist, w_dset;
    logic [MAG_W-1:0]         w_mag_set;
    logic signed [PROD_W-1:0] w_p, w_q;
    logic [NUM_W-1:0]         w_spd_prod;
    logic [DIV_W-1:0]         w_quo;
    logic [63:0]              w_quo64;
    logic [30:0]              w_ms_sat;
    logic                     w_div_done;
    logic                     w_div_start;
    logic [31:0]              w_rem_init, w_divisor;
    logic [DIV_W-1:0]         w_dividend;
    logic [CNT_W-1:0]         w_count;

    assign w_dur = r_et - r_st;
    assign w_el  = r_now - r_st;

    assign w_delta = $signed({r_ev[31], r_ev}) - $signed({r_sv[31], r_sv});
    assign w_dist  = $signed({r_smp[31], r_smp}) - $signed({r_goal[31], r_goal});
    assign w_dset  = $signed({r_goal[31], r_goal}) - $signed({r_sv[31], r_sv});
    assign w_mag_set = w_dset[MAG_W-1] ? MAG_W'(-w_dset) : MAG_W'(w_dset);

    assign w_p = r_prod + HALF;
    assign w_q = w_p >>> T_FRAC;

    assign w_spd_prod = {{TIME_SCALE_W{1'b0}}, r_mag} * NUM_W'(TIME_SCALE);

    assign w_quo64  = 64'(w_quo);
    assign w_ms_sat = (w_quo64 > {33'b0, MAX_RAMP_MS}) ? MAX_RAMP_MS : w_quo64[30:0];

    // The fraction division starts from half the elapsed time as remainder,
    // which is below the duration, so only the last 17 bits need iterating.
    always_comb begin
        w_div_start = i_cmd.div_frac | i_cmd.div_spd;
        if (i_cmd.div_spd) begin
            w_rem_init = '0;
            w_divisor  = {16'b0, r_speed};
            w_dividend = r_num;
            w_count    = CNT_W'(DIV_W);
        end else begin
            w_rem_init = {1'b0, w_el[31:1]};
            w_divisor  = w_dur;
            w_dividend = {w_el[0], {(DIV_W-1){1'b0}}};
            w_count    = CNT_W'(FRAC_ITER);
        end
    end

    tlr_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init (w_rem_init),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_count    (w_count),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv        <= '0;
            r_ev        <= '0;
            r_st        <= '0;
            r_et        <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.smp_stop) begin
                r_active <= 1'b0;
            end
            if (i_cmd.smp_end) begin
                r_sv     <= r_ev;
                r_st     <= r_et;
                r_active <= 1'b0;
            end
            if (i_cmd.sv_from_smp) begin
                r_sv <= r_smp;
            end
            if (i_cmd.snap) begin
                r_sv     <= r_goal;
                r_ev     <= r_goal;
                r_active <= 1'b0;
            end
            if (i_cmd.start_ramp) begin
                r_st     <= r_now;
                r_et     <= r_now + {1'b0, r_ms};
                r_ev     <= r_goal;
                r_active <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.load_in) begin
            r_goal  <= i_goal_value;
            r_ms    <= i_ramp_ms;
            r_speed <= i_units_per_second;
            r_now   <= i_now_ms;
        end else if (i_cmd.ms_from_div) begin
            r_ms <= w_ms_sat;
        end

        if (i_cmd.smp_idle || i_cmd.smp_stop) begin
            r_smp <= r_sv;
        end else if (i_cmd.smp_end) begin
            r_smp <= r_ev;
        end else if (i_cmd.add) begin
            r_smp <= r_sv + w_q[31:0];
        end

        if (i_cmd.mul) begin
            r_prod <= PROD_W'(w_delta) * PROD_W'($signed({1'b0, w_quo[T_FRAC:0]}));
        end
        if (i_cmd.spd_abs) begin
            r_mag <= w_dist[MAG_W-1] ? MAG_W'(-w_dist) : MAG_W'(w_dist);
        end
        if (i_cmd.spd_mul) begin
            r_num <= w_spd_prod[NUM_W-1:FRAC_BITS];
        end

        if (i_cmd.out_load) begin
            r_out_cur  <= i_cmd.out_sel_smp ? r_smp : r_sv;
            r_out_goal <= r_ev;
            r_out_ramp <= r_active;
        end
    end

    always_comb begin
        o_stat.active       = r_active;
        o_stat.dur_zero     = (w_dur == '0);
        o_stat.el_gt_dur    = (w_el > w_dur);
        o_stat.ms_zero      = (r_ms == '0);
        o_stat.sv_eq_goal   = (r_sv == r_goal);
        o_stat.smp_eq_goal  = (r_smp == r_goal);
        o_stat.speed_zero   = (r_speed == '0);
        o_stat.below_thresh = (w_mag_set < MAG_W'(THRESH));
        o_stat.div_done     = w_div_done;
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_value = r_out_cur;
    assign o_goal_out      = r_out_goal;
    assign o_ramping       = r_out_ramp;

    a_start_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_ramp |=> r_active && (r_ev == $past(r_goal)))
        else $error("ramp start did not take the goal");

    a_smp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.smp_end |=> !r_active && (r_sv == r_ev) && (r_st == r_et))
        else $error("finished ramp left inconsistent state");

    a_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.snap |=> !r_active && (r_sv == r_ev))
        else $error("snap left start and end apart");

endmodule

### src/tlr_ctrl.sv
// ----------------------------------------------------------------------------
// tlr_ctrl: sequencing state machine
// Accepts one transaction at a time, walks it through sampling, the speed
// duration and the ramp update, then loads the result register.
// ----------------------------------------------------------------------------
module tlr_ctrl
    import tlr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_operation,
    output logic       o_in_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op <= n_op;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = i_operation;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_op == OP_SET_DUR) begin
                    priority if (i_stat.ms_zero) begin
                        o_cmd.snap = 1'b1;
                        n_state    = S_DONE;
                    end else if (i_stat.active) begin
                        n_state = S_CHK;
                    end else if (i_stat.sv_eq_goal) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SET;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                priority if (!i_stat.active) begin
                    o_cmd.smp_idle = 1'b1;
                    n_state        = S_POST;
                end else if (i_stat.dur_zero) begin
                    o_cmd.smp_stop = 1'b1;
                    n_state        = S_POST;
                end else if (i_stat.el_gt_dur) begin
                    o_cmd.smp_end = 1'b1;
                    n_state       = S_POST;
                end else begin
                    o_cmd.div_frac = 1'b1;
                    n_state        = S_FDIV;
                end
            end
            S_FDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_POST;
            end
            S_POST: begin
                unique case (r_op)
                    OP_SET_DUR: begin
                        o_cmd.sv_from_smp = 1'b1;
                        n_state           = S_SET;
                    end
                    OP_SET_SPEED: begin
                        if (i_stat.smp_eq_goal || i_stat.speed_zero) begin
                            o_cmd.snap = 1'b1;
                            n_state    = S_DONE;
                        end else begin
                            n_state = S_SPD_ABS;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SPD_ABS: begin
                o_cmd.spd_abs = 1'b1;
                n_state       = S_SPD_MUL;
            end
            S_SPD_MUL: begin
                o_cmd.spd_mul = 1'b1;
                n_state       = S_SPD_DIVS;
            end
            S_SPD_DIVS: begin
                o_cmd.div_spd = 1'b1;
                n_state       = S_SDIV;
            end
            S_SDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_SMS;
                end
            end
            S_SMS: begin
                o_cmd.ms_from_div = 1'b1;
                n_state           = S_SMS2;
            end
            S_SMS2: begin
                // With a nonzero duration the start value takes the
                // sampled value, so the ramp restarts from there.
                if (i_stat.ms_zero) begin
                    o_cmd.snap = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.sv_from_smp = 1'b1;
                    n_state           = S_SET;
                end
            end
            S_SET: begin
                if (i_stat.below_thresh) begin
                    o_cmd.snap = 1'b1;
                end else begin
                    o_cmd.start_ramp = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.out_sel_smp = (r_op != OP_SET_DUR) && (r_op != OP_SET_SPEED);
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result register overwritten while held");

    a_one_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_frac || o_cmd.div_spd) |=> (r_state == S_FDIV) || (r_state == S_SDIV))
        else $error("divider started outside a wait state");

endmodule

### src/timed_linear_ramp_top.sv
// Throughput: one transaction at a time; the next is accepted in the cycle
// after the result register is loaded, even while that result is still held.
// Reset (synchronous, active low): value, goal and times zero, not ramping.
// ----------------------------------------------------------------------------
// timed_linear_ramp_top: linear interpolation ramp generator
// A Q16.16 value ramps linearly toward a goal over a time set directly or
// derived from a speed; samples return the interpolated value.
// ----------------------------------------------------------------------------
module timed_linear_ramp_top
    import tlr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_goal_value,
    input  logic [30:0]        i_ramp_ms,
    input  logic [15:0]        i_units_per_second,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_current_value,
    output logic signed [31:0] o_goal_out,
    output logic               o_ramping
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tlr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_goal_value       (i_goal_value),
        .i_ramp_ms          (i_ramp_ms),
        .i_units_per_second (i_units_per_second),
        .i_now_ms           (i_now_ms),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_current_value    (o_current_value),
        .o_goal_out         (o_goal_out),
        .o_ramping          (o_ramping)
    );

endmodule
